@@ hdl/fla_pkg.sv @@
// Shared types and codes for the free list allocator.
package fla_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic FIT_FIRST = 1'b0;

  localparam int unsigned ALIGN_BITS = 13;
  localparam int unsigned CFG_BITS   = 17;

endpackage

@@ hdl/fla_req_if.sv @@
// Request and response channel interfaces of the free list allocator.
interface fla_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] req_size;
  logic [12:0] alignment;
  logic        fit_mode;
  logic [15:0] block_offset;
  logic [15:0] block_size;

  modport source (output valid, kind, req_size, alignment, fit_mode, block_offset, block_size,
                  input ready);
  modport sink   (input valid, kind, req_size, alignment, fit_mode, block_offset, block_size,
                  output ready);
endinterface

interface fla_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] data_offset;

  modport source (output valid, status, data_offset, input ready);
  modport sink   (input valid, status, data_offset, output ready);
endinterface

@@ hdl/fla_fit_unit.sv @@
// Alignment padding and space need for one extent.
module fla_fit_unit
  import fla_pkg::*;
#(
  parameter int unsigned HEADER_BYTES   = 8,
  parameter int unsigned POOL_ADDR_BITS = 16,
  parameter int unsigned NW             = 18
) (
  input  logic [POOL_ADDR_BITS-1:0] start_i,
  input  logic [ALIGN_BITS-1:0]     mask_i,
  input  logic [NW-1:0]             szh_i,
  output logic [ALIGN_BITS-1:0]     pad_o,
  output logic [NW-1:0]             need_o
);

  logic [NW-1:0] base;

  assign base   = NW'(start_i) + NW'(HEADER_BYTES);
  // distance up to the next aligned address is the negated base under the mask
  assign pad_o  = (ALIGN_BITS'(0) - base[ALIGN_BITS-1:0]) & mask_i;
  assign need_o = NW'(pad_o) + szh_i;

endmodule

@@ hdl/free_list_allocator_top.sv @@
// Free list allocator: address-ordered free extent table with alloc and free.
//
// A request is accepted in S_IDLE, then walks the linked extents one entry at a time: S_AW1 and
// S_AW2 per extent for allocate, through the padding unit, or S_FWALK per extent for free. Then
// come a decision state (S_ADEC or S_FCHK), an optional scan of up to FREE_ENTRIES slots for an
// empty one and the S_APPLY update. The result waits in an output register, so the next request
// is taken while it is pending. Writing pool_size resets the table to one free extent.
module free_list_allocator_top
  import fla_pkg::*;
#(
  parameter int unsigned FREE_ENTRIES   = 16,
  parameter int unsigned HEADER_BYTES   = 8,
  parameter int unsigned POOL_ADDR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  fla_req_if.sink             req,
  fla_rsp_if.source           rsp
);

  localparam int unsigned A    = POOL_ADDR_BITS;
  localparam int unsigned LW   = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned IW   = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned LENW = A + 1;
  localparam int unsigned NW   = ((A + 1 > 17) ? A + 1 : 17) + 1;
  localparam logic [LW-1:0]   NIL      = LW'(FREE_ENTRIES);
  localparam logic [LW-1:0]   LAST     = LW'(FREE_ENTRIES - 1);
  localparam logic [LENW-1:0] RST_POOL = LENW'(64'd1 << ((A >= 16) ? 16 : A));
  localparam logic [NW-1:0]   LIMIT    = NW'(64'd1 << A);

  typedef enum logic [3:0] {
    S_IDLE, S_AW1, S_AW2, S_ADEC, S_FWALK, S_FCHK, S_SCAN, S_APPLY, S_DONE
  } state_e;

  state_e state_q;

  logic [A-1:0]    start_q [FREE_ENTRIES];
  logic [LENW-1:0] len_q   [FREE_ENTRIES];
  logic [LW-1:0]   link_q  [FREE_ENTRIES];
  logic [LW-1:0]   head_q;
  logic [LENW-1:0] pool_q;

  logic                  kind_q, fit_q;
  logic [ALIGN_BITS-1:0] mask_q;
  logic [NW-1:0]         szh_q;
  logic [A-1:0]          bs_q;
  logic [LENW-1:0]       be_q;
  logic [LW-1:0]         cur_q, prev_q, steps_q, scan_q, slot_q;
  logic [LW-1:0]         tgt_q, tprev_q, t_link_q;
  logic [A-1:0]          t_start_q, p_start_q;
  logic [LENW-1:0]       t_len_q, p_len_q;
  logic [ALIGN_BITS-1:0] t_pad_q, a_pad_q;
  logic [NW-1:0]         t_need_q, a_need_q, best_q;
  logic                  found_q, left_q, right_q;
  logic [1:0]            res_st_q, st_q;
  logic [15:0]           res_data_q, data_q;
  logic                  ovld_q;

  logic [IW-1:0]         rd_idx;
  logic [A-1:0]          rd_start;
  logic [LENW-1:0]       rd_len;
  logic [LW-1:0]         rd_link;
  logic [ALIGN_BITS-1:0] fu_pad;
  logic [NW-1:0]         fu_need, diff, fe_sum, cfg_v, c_end;
  logic                  fits, alloc_bad, free_bad, left, right;

  // one table read port, shared by the walk and the slot scan
  assign rd_idx   = (state_q == S_SCAN) ? scan_q[IW-1:0] : cur_q[IW-1:0];
  assign rd_start = start_q[rd_idx];
  assign rd_len   = len_q[rd_idx];
  assign rd_link  = link_q[rd_idx];

  fla_fit_unit #(
    .HEADER_BYTES  (HEADER_BYTES),
    .POOL_ADDR_BITS(POOL_ADDR_BITS),
    .NW            (NW)
  ) u_fit (
    .start_i(rd_start),
    .mask_i (mask_q),
    .szh_i  (szh_q),
    .pad_o  (fu_pad),
    .need_o (fu_need)
  );

  assign fits  = NW'(rd_len) >= a_need_q;
  assign diff  = NW'(rd_len) - a_need_q;
  assign alloc_bad = (req.req_size == 16'd0) || (req.alignment == 13'd0) ||
                     ((req.alignment & (req.alignment - 13'd1)) != 13'd0);
  assign fe_sum   = NW'(req.block_offset) + NW'(req.block_size);
  assign free_bad = (req.block_size == 16'd0) || (NW'(req.block_offset) < NW'(HEADER_BYTES)) ||
                    (fe_sum > NW'(pool_q));
  assign left   = (prev_q != NIL) && (NW'(p_start_q) + NW'(p_len_q) == NW'(bs_q));
  assign right  = (cur_q != NIL) && (rd_start == be_q[A-1:0]) && (be_q[A] == 1'b0);
  assign c_end  = NW'(t_start_q) + NW'(t_len_q);

  always_comb begin
    cfg_v = NW'(cfg_data_i);
    if (cfg_v == NW'(0)) begin
      cfg_v = NW'(1);
    end else if (cfg_v > LIMIT) begin
      cfg_v = LIMIT;
    end
  end

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = ovld_q;
  assign rsp.status      = st_q;
  assign rsp.data_offset = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < FREE_ENTRIES; i++) begin
        start_q[i] <= '0;
        len_q[i]   <= '0;
        link_q[i]  <= NIL;
      end
      len_q[0]   <= RST_POOL;
      head_q     <= '0;
      pool_q     <= RST_POOL;
      kind_q     <= KIND_ALLOC;
      fit_q      <= FIT_FIRST;
      mask_q     <= '0;
      szh_q      <= '0;
      bs_q       <= '0;
      be_q       <= '0;
      cur_q      <= NIL;
      prev_q     <= NIL;
      steps_q    <= '0;
      scan_q     <= '0;
      slot_q     <= '0;
      tgt_q      <= NIL;
      tprev_q    <= NIL;
      t_link_q   <= NIL;
      t_start_q  <= '0;
      p_start_q  <= '0;
      t_len_q    <= '0;
      p_len_q    <= '0;
      t_pad_q    <= '0;
      a_pad_q    <= '0;
      t_need_q   <= '0;
      a_need_q   <= '0;
      best_q     <= '1;
      found_q    <= 1'b0;
      left_q     <= 1'b0;
      right_q    <= 1'b0;
      res_st_q   <= ST_OK;
      res_data_q <= '0;
      st_q       <= ST_OK;
      data_q     <= '0;
      ovld_q     <= 1'b0;
    end else begin
      if (ovld_q && rsp.ready) begin
        ovld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pool_q <= LENW'(cfg_v);
        for (int i = 0; i < FREE_ENTRIES; i++) begin
          start_q[i] <= '0;
          len_q[i]   <= '0;
          link_q[i]  <= NIL;
        end
        len_q[0] <= LENW'(cfg_v);
        head_q   <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            kind_q     <= req.kind;
            fit_q      <= req.fit_mode;
            mask_q     <= req.alignment - 13'd1;
            szh_q      <= NW'(req.req_size) + NW'(HEADER_BYTES);
            bs_q       <= A'(NW'(req.block_offset) - NW'(HEADER_BYTES));
            be_q       <= LENW'(fe_sum);
            cur_q      <= head_q;
            prev_q     <= NIL;
            steps_q    <= '0;
            found_q    <= 1'b0;
            best_q     <= '1;
            res_st_q   <= ST_OK;
            res_data_q <= '0;
            if (req.kind == KIND_ALLOC) begin
              if (alloc_bad) begin
                res_st_q <= ST_INVALID;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_AW1;
              end
            end else begin
              if (free_bad) begin
                res_st_q <= ST_INVALID;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_FWALK;
              end
            end
          end
        end
        S_AW1: begin
          if (steps_q == NIL || cur_q == NIL) begin
            state_q <= S_ADEC;
          end else begin
            a_pad_q  <= fu_pad;
            a_need_q <= fu_need;
            state_q  <= S_AW2;
          end
        end
        S_AW2: begin
          if (fits && (fit_q == FIT_FIRST || diff < best_q)) begin
            best_q    <= diff;
            found_q   <= 1'b1;
            tgt_q     <= cur_q;
            tprev_q   <= prev_q;
            t_start_q <= rd_start;
            t_len_q   <= rd_len;
            t_link_q  <= rd_link;
            t_pad_q   <= a_pad_q;
            t_need_q  <= a_need_q;
          end
          if (fits && fit_q == FIT_FIRST) begin
            state_q <= S_ADEC;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= rd_link;
            steps_q <= steps_q + LW'(1);
            state_q <= S_AW1;
          end
        end
        S_ADEC: begin
          if (!found_q) begin
            res_st_q <= ST_NOMEM;
            state_q  <= S_DONE;
          end else begin
            res_data_q <= 16'(NW'(t_start_q) + NW'(HEADER_BYTES) + NW'(t_pad_q));
            scan_q     <= '0;
            if (t_need_q == NW'(t_len_q) || t_pad_q == '0) begin
              state_q <= S_APPLY;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_FWALK: begin
          if (steps_q == NIL) begin
            cur_q   <= NIL;
            state_q <= S_FCHK;
          end else if (cur_q == NIL || rd_start >= bs_q) begin
            state_q <= S_FCHK;
          end else begin
            p_start_q <= rd_start;
            p_len_q   <= rd_len;
            prev_q    <= cur_q;
            cur_q     <= rd_link;
            steps_q   <= steps_q + LW'(1);
          end
        end
        S_FCHK: begin
          left_q    <= left;
          right_q   <= right;
          t_start_q <= rd_start;
          t_len_q   <= rd_len;
          t_link_q  <= rd_link;
          scan_q    <= '0;
          state_q   <= (left || right) ? S_APPLY : S_SCAN;
        end
        S_SCAN: begin
          if (rd_len == '0) begin
            slot_q  <= scan_q;
            state_q <= S_APPLY;
          end else if (scan_q == LAST) begin
            res_st_q   <= ST_FULL;
            res_data_q <= '0;
            state_q    <= S_DONE;
          end else begin
            scan_q <= scan_q + LW'(1);
          end
        end
        S_APPLY: begin
          state_q <= S_DONE;
          if (kind_q == KIND_ALLOC) begin
            if (t_need_q == NW'(t_len_q)) begin
              if (t_pad_q == '0) begin
                if (tprev_q != NIL) link_q[tprev_q[IW-1:0]] <= t_link_q;
                else head_q <= t_link_q;
                start_q[tgt_q[IW-1:0]] <= '0;
                len_q[tgt_q[IW-1:0]]   <= '0;
                link_q[tgt_q[IW-1:0]]  <= NIL;
              end else begin
                len_q[tgt_q[IW-1:0]] <= LENW'(t_pad_q);
              end
            end else if (t_pad_q != '0) begin
              start_q[slot_q[IW-1:0]] <= A'(NW'(t_start_q) + t_need_q);
              len_q[slot_q[IW-1:0]]   <= LENW'(NW'(t_len_q) - t_need_q);
              link_q[slot_q[IW-1:0]]  <= t_link_q;
              link_q[tgt_q[IW-1:0]]   <= slot_q;
              len_q[tgt_q[IW-1:0]]    <= LENW'(t_pad_q);
            end else begin
              start_q[tgt_q[IW-1:0]] <= A'(NW'(t_start_q) + t_need_q);
              len_q[tgt_q[IW-1:0]]   <= LENW'(NW'(t_len_q) - t_need_q);
            end
          end else begin
            if (left_q && right_q) begin
              len_q[prev_q[IW-1:0]]  <= LENW'(c_end - NW'(p_start_q));
              link_q[prev_q[IW-1:0]] <= t_link_q;
              start_q[cur_q[IW-1:0]] <= '0;
              len_q[cur_q[IW-1:0]]   <= '0;
              link_q[cur_q[IW-1:0]]  <= NIL;
            end else if (left_q) begin
              len_q[prev_q[IW-1:0]] <= LENW'(NW'(be_q) - NW'(p_start_q));
            end else if (right_q) begin
              len_q[cur_q[IW-1:0]]   <= LENW'(c_end - NW'(bs_q));
              start_q[cur_q[IW-1:0]] <= bs_q;
            end else begin
              start_q[slot_q[IW-1:0]] <= bs_q;
              len_q[slot_q[IW-1:0]]   <= LENW'(NW'(be_q) - NW'(bs_q));
              link_q[slot_q[IW-1:0]]  <= cur_q;
              if (prev_q != NIL) link_q[prev_q[IW-1:0]] <= slot_q;
              else head_q <= slot_q;
            end
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!ovld_q || rsp.ready) begin
            st_q    <= res_st_q;
            data_q  <= (res_st_q == ST_OK && kind_q == KIND_ALLOC) ? res_data_q : 16'd0;
            ovld_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.data_offset == 16'd0))
    else $error("error response carries a data offset");

  a_cfg_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (head_q == '0 && len_q[0] == pool_q))
    else $error("pool write did not rebuild the table");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AW2) |-> (steps_q < NIL && cur_q != NIL))
    else $error("extent walk ran past its bound");

  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!ovld_q || rsp.ready)) |=> (ovld_q && state_q == S_IDLE))
    else $error("finished result was not loaded");

endmodule
